/* rtl/core/xhtml_escape_utf8_encoder_top_assert.svh */
// Assertion macros shared by the encoder modules.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef XHTML_ESCAPE_UTF8_ENCODER_TOP_ASSERT_SVH
`define XHTML_ESCAPE_UTF8_ENCODER_TOP_ASSERT_SVH

`define XEE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`define XEE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/xee_pkg.sv */
package xee_pkg;

  localparam logic [15:0] UnitCr     = 16'h000D;
  localparam logic [15:0] UnitLf     = 16'h000A;
  localparam logic [15:0] UnitQmark  = 16'h003F;
  localparam logic [15:0] UnitAmp    = 16'h0026;
  localparam logic [15:0] UnitLt     = 16'h003C;
  localparam logic [15:0] UnitGt     = 16'h003E;
  localparam logic [15:0] UnitApos   = 16'h0027;
  localparam logic [15:0] UnitQuot   = 16'h0022;
  localparam logic [15:0] UnitLsep   = 16'h2028;
  localparam logic [15:0] UnitPsep   = 16'h2029;
  localparam logic [5:0]  HighPrefix = 6'b110110;
  localparam logic [20:0] SuppBase   = 21'h10000;

  // Entity texts, first character in the lowest byte.
  localparam logic [47:0] TextAmp  = 48'h003B706D6126;
  localparam logic [47:0] TextLt   = 48'h00003B746C26;
  localparam logic [47:0] TextGt   = 48'h00003B746726;
  localparam logic [47:0] TextApos = 48'h3B736F706126;
  localparam logic [47:0] TextQuot = 48'h3B746F757126;
  localparam logic [47:0] TextBr   = 48'h003E2F72623C;

  typedef enum logic [1:0] {
    BODY_NONE,
    BODY_TEXT,
    BODY_UNITS
  } body_kind_t;

  typedef enum logic [2:0] {
    TXT_AMP,
    TXT_LT,
    TXT_GT,
    TXT_APOS,
    TXT_QUOT,
    TXT_BR
  } txt_id_t;

  typedef struct packed {
    logic [2:0]       n;
    logic [3:0][15:0] units;
  } xee_units_t;

  typedef struct packed {
    logic        pre_v;
    logic [15:0] pre_unit;
    body_kind_t  kind;
    txt_id_t     txt;
    xee_units_t  body;
    logic        last;
  } xee_cmd_t;

  function automatic logic [2:0] txt_len(txt_id_t id);
    logic [2:0] len;
    case (id)
      TXT_AMP:  len = 3'd5;
      TXT_LT:   len = 3'd4;
      TXT_GT:   len = 3'd4;
      TXT_APOS: len = 3'd6;
      TXT_QUOT: len = 3'd6;
      TXT_BR:   len = 3'd5;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] txt_char(txt_id_t id, logic [2:0] pos);
    logic [47:0] s;
    case (id)
      TXT_AMP:  s = TextAmp;
      TXT_LT:   s = TextLt;
      TXT_GT:   s = TextGt;
      TXT_APOS: s = TextApos;
      TXT_QUOT: s = TextQuot;
      TXT_BR:   s = TextBr;
      default:  s = '0;
    endcase
    return s[{pos, 3'b000} +: 8];
  endfunction

endpackage

/* rtl/core/xee_chan_if.sv */
interface xee_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

interface xee_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_unit;
  logic        last_out;

  modport source (output valid, output out_unit, output last_out, input ready);
  modport sink (input valid, input out_unit, input last_out, output ready);
endinterface

interface xee_cfg_if;
  logic valid;
  logic ready;
  logic utf8_mode;

  modport source (output valid, output utf8_mode, input ready);
  modport sink (input valid, input utf8_mode, output ready);
endinterface

/* rtl/core/xee_front.sv */
`include "xhtml_escape_utf8_encoder_top_assert.svh"

module xee_front (
  input  logic              clk,
  input  logic              rst_n,
  xee_in_if.sink            in_ch,
  xee_cfg_if.sink           cfg_ch,
  input  logic              q_full,
  output logic              q_push,
  output xee_pkg::xee_cmd_t q_cmd
);
  import xee_pkg::*;

  logic       utf8_mode_r;
  logic       cr_pending_r, cr_pending_nxt;
  logic       high_pending_r, high_pending_nxt;
  logic [9:0] held_r, held_nxt;
  logic       in_fire;
  logic       done;
  logic       is_high, is_low;
  logic [15:0] u;
  logic [20:0] pair_cp;
  xee_cmd_t   cmd;

  function automatic xee_units_t utf8_enc(logic [20:0] cp);
    xee_units_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.n = 3'd1;
      r.units[0] = {9'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      r.n = 3'd2;
      r.units[0] = {8'b0, 3'b110, cp[10:6]};
      r.units[1] = {8'b0, 2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.n = 3'd3;
      r.units[0] = {8'b0, 4'b1110, cp[15:12]};
      r.units[1] = {8'b0, 2'b10, cp[11:6]};
      r.units[2] = {8'b0, 2'b10, cp[5:0]};
    end else begin
      r.n = 3'd4;
      r.units[0] = {8'b0, 5'b11110, cp[20:18]};
      r.units[1] = {8'b0, 2'b10, cp[17:12]};
      r.units[2] = {8'b0, 2'b10, cp[11:6]};
      r.units[3] = {8'b0, 2'b10, cp[5:0]};
    end
    return r;
  endfunction

  function automatic xee_units_t one_unit(logic [15:0] v);
    xee_units_t r;
    r = '0;
    r.n = 3'd1;
    r.units[0] = v;
    return r;
  endfunction

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && !q_full;
  assign u            = in_ch.code_unit;
  assign is_high      = u inside {[16'hD800:16'hDBFF]};
  assign is_low       = u inside {[16'hDC00:16'hDFFF]};
  assign pair_cp      = SuppBase + {1'b0, held_r, u[9:0]};

  always_comb begin
    cmd              = '0;
    cmd.kind         = BODY_NONE;
    cmd.txt          = TXT_AMP;
    cmd.last         = in_ch.last_unit;
    cr_pending_nxt   = cr_pending_r;
    high_pending_nxt = high_pending_r;
    held_nxt         = held_r;
    done             = 1'b0;
    if (in_fire) begin
      cr_pending_nxt   = 1'b0;
      high_pending_nxt = 1'b0;
      if (high_pending_r) begin
        if (utf8_mode_r && is_low) begin
          cmd.kind = BODY_UNITS;
          cmd.body = utf8_enc(pair_cp);
          done     = 1'b1;
        end else begin
          cmd.pre_v    = 1'b1;
          cmd.pre_unit = utf8_mode_r ? UnitQmark : {HighPrefix, held_r};
        end
      end
      if (!done && cr_pending_r) begin
        if (u == UnitLf) begin
          cmd.kind = BODY_TEXT;
          cmd.txt  = TXT_BR;
          done     = 1'b1;
        end else begin
          cmd.pre_v    = 1'b1;
          cmd.pre_unit = UnitCr;
        end
      end
      if (!done) begin
        if (u == UnitCr) begin
          if (in_ch.last_unit) begin
            cmd.kind = BODY_UNITS;
            cmd.body = one_unit(UnitCr);
          end else begin
            cr_pending_nxt = 1'b1;
          end
        end else if (utf8_mode_r && is_high) begin
          if (in_ch.last_unit) begin
            cmd.kind = BODY_UNITS;
            cmd.body = one_unit(UnitQmark);
          end else begin
            high_pending_nxt = 1'b1;
            held_nxt         = u[9:0];
          end
        end else if (utf8_mode_r && is_low) begin
          cmd.kind = BODY_UNITS;
          cmd.body = one_unit(UnitQmark);
        end else begin
          cmd.kind = BODY_TEXT;
          case (u)
            UnitAmp:  cmd.txt = TXT_AMP;
            UnitLt:   cmd.txt = TXT_LT;
            UnitGt:   cmd.txt = TXT_GT;
            UnitApos: cmd.txt = TXT_APOS;
            UnitQuot: cmd.txt = TXT_QUOT;
            UnitLf, UnitLsep, UnitPsep: cmd.txt = TXT_BR;
            default: begin
              cmd.kind = BODY_UNITS;
              cmd.body = utf8_mode_r ? utf8_enc({5'b0, u}) : one_unit(u);
            end
          endcase
        end
      end
    end
  end

  assign q_cmd  = cmd;
  assign q_push = in_fire && (cmd.pre_v || cmd.kind != BODY_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf8_mode_r    <= 1'b1;
      cr_pending_r   <= 1'b0;
      high_pending_r <= 1'b0;
      held_r         <= '0;
    end else begin
      if (cfg_ch.valid) begin
        utf8_mode_r <= cfg_ch.utf8_mode;
      end
      cr_pending_r   <= cr_pending_nxt;
      high_pending_r <= high_pending_nxt;
      held_r         <= held_nxt;
    end
  end

  `XEE_ASSERT_ALWAYS(a_pending_excl, !(cr_pending_r && high_pending_r), "both CR and surrogate held")
  `XEE_ASSERT_NEXT(a_last_flush, in_fire && in_ch.last_unit, !cr_pending_r && !high_pending_r, "pending state survived a last request")

endmodule

/* rtl/core/xee_fifo.sv */
`include "xhtml_escape_utf8_encoder_top_assert.svh"

module xee_fifo #(
  parameter int Depth = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xee_pkg::xee_cmd_t push_cmd,
  input  logic              pop,
  output xee_pkg::xee_cmd_t head_cmd,
  output logic              empty,
  output logic              full
);
  import xee_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  xee_cmd_t          mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CntW'(Depth));
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `XEE_ASSERT_ALWAYS(a_no_overflow, !(push && full), "queue written while full")
  `XEE_ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "queue read while empty")

endmodule

/* rtl/core/xee_back.sv */
`include "xhtml_escape_utf8_encoder_top_assert.svh"

module xee_back (
  input  logic              clk,
  input  logic              rst_n,
  input  xee_pkg::xee_cmd_t head_cmd,
  input  logic              q_empty,
  output logic              q_pop,
  xee_out_if.source         out_ch
);
  import xee_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_unit_r, out_unit_nxt;
  logic        last_out_r, last_out_nxt;
  logic [2:0]  pre_len, body_len, total, pos;
  logic        at_end, advance, take;
  logic [15:0] unit;

  assign pre_len = {2'b0, head_cmd.pre_v};

  always_comb begin
    case (head_cmd.kind)
      BODY_TEXT:  body_len = txt_len(head_cmd.txt);
      BODY_UNITS: body_len = head_cmd.body.n;
      default:    body_len = 3'd0;
    endcase
  end

  assign total  = pre_len + body_len;
  assign pos    = idx_r - pre_len;
  assign at_end = (idx_r == total - 3'd1);

  always_comb begin
    if (head_cmd.pre_v && idx_r == 3'd0) begin
      unit = head_cmd.pre_unit;
    end else if (head_cmd.kind == BODY_TEXT) begin
      unit = {8'b0, txt_char(head_cmd.txt, pos)};
    end else begin
      unit = head_cmd.body.units[pos[1:0]];
    end
  end

  assign advance = !out_valid_r || out_ch.ready;
  assign take    = advance && !q_empty;
  assign q_pop   = take && at_end;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_unit_nxt  = out_unit_r;
    last_out_nxt  = last_out_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_unit_nxt  = unit;
      last_out_nxt  = head_cmd.last && at_end;
      idx_nxt       = at_end ? 3'd0 : idx_r + 3'd1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_unit_r <= out_unit_nxt;
    last_out_r <= last_out_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_unit = out_unit_r;
  assign out_ch.last_out = last_out_r;

  `XEE_ASSERT_ALWAYS(a_idx_bound, q_empty || idx_r < total, "expansion index past end of request")
  `XEE_ASSERT_ALWAYS(a_idx_idle, !q_empty || idx_r == 3'd0, "expansion index left over on empty queue")

endmodule

/* rtl/core/xhtml_escape_utf8_encoder_top.sv */
// Channel | Role            | Payload
// in_ch   | request in      | code_unit[15:0], last_unit
// out_ch  | result out      | out_unit[15:0], last_out
// cfg_ch  | mode write      | utf8_mode, always ready
//
// The front part accepts one request per cycle while the queue has room.
// The back part sends one result per cycle while out_ch is ready, and a request
// expands to 1 to 7 results; the queue of FIFO_DEPTH entries absorbs bursts, and
// a request is written to the queue on acceptance and from there to the output register.
// Reset is synchronous and active low; it sets UTF-8 mode and clears held state.
// A stalled result holds in the output register while the front part continues until the queue is full.
module xhtml_escape_utf8_encoder_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  xee_in_if.sink    in_ch,
  xee_out_if.source out_ch,
  xee_cfg_if.sink   cfg_ch
);
  import xee_pkg::*;

  xee_cmd_t push_cmd;
  xee_cmd_t head_cmd;
  logic     q_push, q_pop, q_empty, q_full;

  xee_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  xee_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  xee_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule

/* tb/sv/tb.sv */
module tb;
  import xee_pkg::*;

  localparam logic [5:0] LowPrefix = 6'b110111;
  localparam int CycleLimit = 100000;
  localparam int SettleCycles = 16;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } text_req_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        last_out;
  } escaped_t;

  logic clk;
  logic rst_n;
  int cycles;
  int errors;
  int reqs_queued;
  int reqs_taken;
  logic in_fire;

  text_req_t pending_reqs[$];
  escaped_t escaped_q[$];
  logic [15:0] step_units[$];

  logic pred_utf8 = 1'b1;
  logic pred_cr = 1'b0;
  logic pred_high = 1'b0;
  logic [9:0] pred_held = '0;

  xee_in_if in_ch();
  xee_out_if out_ch();
  xee_cfg_if cfg_ch();

  xhtml_escape_utf8_encoder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void put_unit(logic [15:0] v);
    step_units.push_back(v);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      put_unit(16'(s[i]));
    end
  endfunction

  function automatic void put_codepoint(logic [20:0] cp);
    if (!pred_utf8) begin
      put_unit(cp[15:0]);
    end else if (cp < 21'h80) begin
      put_unit(cp[15:0]);
    end else if (cp < 21'h800) begin
      put_unit(16'h00C0 | 16'(cp[10:6]));
      put_unit(16'h0080 | 16'(cp[5:0]));
    end else if (cp < 21'h10000) begin
      put_unit(16'h00E0 | 16'(cp[15:12]));
      put_unit(16'h0080 | 16'(cp[11:6]));
      put_unit(16'h0080 | 16'(cp[5:0]));
    end else begin
      put_unit(16'h00F0 | 16'(cp[20:18]));
      put_unit(16'h0080 | 16'(cp[17:12]));
      put_unit(16'h0080 | 16'(cp[11:6]));
      put_unit(16'h0080 | 16'(cp[5:0]));
    end
  endfunction

  function automatic void escape_plain(logic [15:0] u, logic last);
    if (u == UnitCr) begin
      if (last) put_unit(UnitCr);
      else pred_cr = 1'b1;
    end else if (pred_utf8 && u[15:10] == HighPrefix) begin
      if (last) begin
        put_unit(UnitQmark);
      end else begin
        pred_high = 1'b1;
        pred_held = u[9:0];
      end
    end else if (pred_utf8 && u[15:10] == LowPrefix) begin
      put_unit(UnitQmark);
    end else begin
      case (u)
        UnitAmp: put_text("&amp;");
        UnitLt: put_text("&lt;");
        UnitGt: put_text("&gt;");
        UnitApos: put_text("&apos;");
        UnitQuot: put_text("&quot;");
        UnitLf, UnitLsep, UnitPsep: put_text("<br/>");
        default: put_codepoint({5'd0, u});
      endcase
    end
  endfunction

  // A request that leaves a CR or a high surrogate held gives no result for that unit yet.
  function automatic void escape_request(logic [15:0] u, logic last);
    escaped_t r;
    logic done;
    done = 1'b0;
    step_units.delete();
    if (pred_high) begin
      pred_high = 1'b0;
      if (pred_utf8 && u[15:10] == LowPrefix) begin
        put_codepoint(SuppBase + {1'b0, pred_held, u[9:0]});
        done = 1'b1;
      end else if (pred_utf8) begin
        put_unit(UnitQmark);
      end else begin
        put_unit({HighPrefix, pred_held});
      end
    end
    if (!done && pred_cr) begin
      pred_cr = 1'b0;
      if (u == UnitLf) begin
        put_text("<br/>");
        done = 1'b1;
      end else begin
        put_unit(UnitCr);
      end
    end
    if (!done) escape_plain(u, last);
    if (last) begin
      pred_cr = 1'b0;
      pred_high = 1'b0;
    end
    for (int i = 0; i < step_units.size(); i++) begin
      r.out_unit = step_units[i];
      r.last_out = last && (i == step_units.size() - 1);
      escaped_q.push_back(r);
    end
  endfunction

  function automatic logic take_break();
    return ((cycles % 3000) >= 700) && ($urandom_range(99) < 33);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin : watch_channels
    escaped_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) pred_utf8 = cfg_ch.utf8_mode;
      if (out_ch.valid && out_ch.ready) begin
        if (escaped_q.size() == 0) begin
          $error("out_unit: no result expected, got %h", out_ch.out_unit);
          errors++;
        end else begin
          want = escaped_q.pop_front();
          if (out_ch.out_unit !== want.out_unit) begin
            $error("out_unit: expected %h, got %h", want.out_unit, out_ch.out_unit);
            errors++;
          end
          if (out_ch.last_out !== want.last_out) begin
            $error("last_out: expected %b, got %b", want.last_out, out_ch.last_out);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        escape_request(in_ch.code_unit, in_ch.last_unit);
        reqs_taken++;
      end
    end
  end

  always @(negedge clk) begin : drive_requests
    text_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_reqs.size() != 0 && !take_break()) begin
        nxt = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.code_unit <= nxt.code_unit;
        in_ch.last_unit <= nxt.last_unit;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && !take_break();
  end

  task automatic push_req(logic [15:0] u, logic last);
    text_req_t r;
    r.code_unit = u;
    r.last_unit = last;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic push_rand(logic [15:0] u);
    push_req(u, $urandom_range(15) == 0);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (reqs_taken != reqs_queued || escaped_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.utf8_mode <= m;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_text(int n);
    int pick;
    int sent;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        push_rand(16'($urandom_range(32, 126)));
        sent += 1;
      end else if (pick < 40) begin
        case ($urandom_range(4))
          0: push_rand(UnitAmp);
          1: push_rand(UnitLt);
          2: push_rand(UnitGt);
          3: push_rand(UnitApos);
          default: push_rand(UnitQuot);
        endcase
        sent += 1;
      end else if (pick < 48) begin
        push_rand(UnitCr);
        push_rand(UnitLf);
        sent += 2;
      end else if (pick < 54) begin
        push_rand(UnitCr);
        push_rand(16'($urandom_range(0, 65535)));
        sent += 2;
      end else if (pick < 59) begin
        case ($urandom_range(2))
          0: push_rand(UnitLf);
          1: push_rand(UnitLsep);
          default: push_rand(UnitPsep);
        endcase
        sent += 1;
      end else if (pick < 69) begin
        push_rand({HighPrefix, 10'($urandom)});
        push_rand({LowPrefix, 10'($urandom)});
        sent += 2;
      end else if (pick < 73) begin
        push_rand({HighPrefix, 10'($urandom)});
        push_rand(16'($urandom_range(32, 126)));
        sent += 2;
      end else if (pick < 76) begin
        push_rand({LowPrefix, 10'($urandom)});
        sent += 1;
      end else if (pick < 84) begin
        push_rand(16'($urandom_range(16'h0080, 16'h07FF)));
        sent += 1;
      end else if (pick < 92) begin
        push_rand(16'($urandom_range(16'h0800, 16'hFFFF)));
        sent += 1;
      end else begin
        push_rand(16'($urandom_range(0, 65535)));
        sent += 1;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.code_unit = '0;
    in_ch.last_unit = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.utf8_mode = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_req(16'h0000, 1'b0);
    push_req(16'h007F, 1'b0);
    push_req(16'h0080, 1'b0);
    push_req(16'h07FF, 1'b0);
    push_req(16'h0800, 1'b0);
    push_req(16'hFFFF, 1'b0);
    push_req(UnitAmp, 1'b0);
    push_req(UnitLt, 1'b0);
    push_req(UnitGt, 1'b0);
    push_req(UnitApos, 1'b0);
    push_req(UnitQuot, 1'b0);
    push_req(UnitLf, 1'b0);
    push_req(UnitCr, 1'b0);
    push_req(UnitLf, 1'b0);
    push_req(UnitCr, 1'b0);
    push_req(16'h0078, 1'b0);
    push_req(UnitLsep, 1'b0);
    push_req(UnitPsep, 1'b0);
    push_req(16'hDBFF, 1'b0);
    push_req(16'hDFFF, 1'b0);
    push_req(16'hDC00, 1'b0);
    push_req(16'hD800, 1'b0);
    push_req(16'h0061, 1'b0);
    push_req(UnitCr, 1'b1);
    push_req(16'hD800, 1'b1);
    push_req(16'hD83D, 1'b0);
    wait_idle();

    write_mode(1'b0);
    push_req(16'h0041, 1'b0);
    push_req(UnitAmp, 1'b0);
    push_req(16'hDBFF, 1'b0);
    push_req(16'hDC00, 1'b0);
    push_req(UnitCr, 1'b1);
    push_req(UnitCr, 1'b0);
    wait_idle();

    write_mode(1'b1);
    push_req(16'h00E9, 1'b0);
    random_text(110);
    wait_idle();

    write_mode(1'b0);
    random_text(110);
    wait_idle();

    write_mode(1'b1);
    random_text(110);
    wait_idle();
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/xee_pkg.sv
rtl/core/xee_chan_if.sv
rtl/core/xee_front.sv
rtl/core/xee_fifo.sv
rtl/core/xee_back.sv
rtl/core/xhtml_escape_utf8_encoder_top.sv
tb/sv/tb.sv
